[hw/rtl/rtlpm_pkg.sv]
// ----------------------------------------------------------------------------
// rtlpm_pkg
// shared types and constants for the longest-prefix route table
// ----------------------------------------------------------------------------
package rtlpm_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int ADDR_W      = 32;
    localparam int IFACE_W     = 4;
    localparam int METRIC_W    = 16;
    localparam int MODE_W      = 2;

    localparam logic [IFACE_W-1:0] IFACE_LIMIT = IFACE_W'(15);
    localparam logic [IFACE_W-1:0] IFACE_NONE  = '0;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEL    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    // one slot of route storage, interface number kept apart in flops
    typedef struct packed {
        logic [ADDR_W-1:0]   dest;
        logic [ADDR_W-1:0]   mask;
        logic [ADDR_W-1:0]   gw;
        logic [METRIC_W-1:0] metric;
    } t_entry;

    typedef struct packed {
        logic              load;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_idx;
        logic              commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

[hw/rtl/rtlpm_ctrl.sv]
// ----------------------------------------------------------------------------
// rtlpm_ctrl
// sequencer: accepts an item, sweeps all slots, then commits the result
// ----------------------------------------------------------------------------
module rtlpm_ctrl import rtlpm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state            r_state;
    t_state            n_state;
    logic [SLOT_W-1:0] r_idx;
    logic [SLOT_W-1:0] n_idx;
    logic              scan_last;

    assign scan_last = (r_idx == SLOT_W'(TABLE_SLOTS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall    = 1'b1;
        o_cmd.load    = 1'b0;
        o_cmd.rd_en   = 1'b0;
        o_cmd.rd_idx  = r_idx;
        o_cmd.commit  = 1'b0;
        n_idx         = r_idx;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
                n_idx      = '0;
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
                n_idx       = r_idx + SLOT_W'(1);
            end
            ST_DRAIN: begin
                n_idx = r_idx;
            end
            ST_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

[hw/rtl/rtlpm_dp.sv]
// ----------------------------------------------------------------------------
// rtlpm_dp
// route storage, per-slot compare stage, best-match registers, result reg
// ----------------------------------------------------------------------------
module rtlpm_dp import rtlpm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [ADDR_W-1:0]   i_dest_addr,
    input  logic [ADDR_W-1:0]   i_net_mask,
    input  logic [ADDR_W-1:0]   i_gateway_addr,
    input  logic [IFACE_W-1:0]  i_iface_num,
    input  logic [METRIC_W-1:0] i_route_metric,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_status,
    output logic [IFACE_W-1:0]  o_out_iface,
    output logic [ADDR_W-1:0]   o_fwd_addr
);

    // route storage
    t_entry             mem [TABLE_SLOTS];
    logic [IFACE_W-1:0] r_iface [TABLE_SLOTS];

    // held item
    logic [MODE_W-1:0]   r_mode;
    t_entry              r_item;
    logic [IFACE_W-1:0]  r_item_iface;

    // compare stage
    logic                r_cmp_vld;
    logic [SLOT_W-1:0]   r_cmp_idx;
    t_entry              r_rd;
    logic [IFACE_W-1:0]  r_rd_iface;

    // best match so far
    logic                r_found;
    logic [SLOT_W-1:0]   r_pick;
    logic [ADDR_W-1:0]   r_best_mask;
    logic [METRIC_W-1:0] r_best_metric;
    logic [ADDR_W-1:0]   r_best_gw;
    logic [IFACE_W-1:0]  r_best_iface;

    // result register
    logic                r_out_vld;
    logic                r_status;
    logic [IFACE_W-1:0]  r_out_iface;
    logic [ADDR_W-1:0]   r_fwd_addr;

    logic occupied;
    logic hit_add;
    logic hit_del;
    logic hit_lkp;
    logic take;
    logic add_ok;
    logic do_add;
    logic do_del;

    assign occupied = (r_rd_iface != IFACE_NONE);
    assign hit_add  = (r_mode == MODE_ADD) && !r_found && !occupied;
    assign hit_del  = (r_mode == MODE_DEL) && !r_found && occupied &&
                      (r_rd.dest == r_item.dest) && (r_rd.mask == r_item.mask);
    assign hit_lkp  = (r_mode == MODE_LOOKUP) && occupied &&
                      ((r_item.dest & r_rd.mask) == (r_rd.dest & r_rd.mask)) &&
                      (!r_found || (r_rd.mask > r_best_mask) ||
                       ((r_rd.mask == r_best_mask) && (r_rd.metric < r_best_metric)));
    assign take     = r_cmp_vld && (hit_add || hit_del || hit_lkp);

    assign add_ok = (r_item_iface <= IFACE_LIMIT);
    assign do_add = i_cmd.commit && (r_mode == MODE_ADD) && r_found && add_ok;
    assign do_del = i_cmd.commit && (r_mode == MODE_DEL) && r_found;

    assign o_sts.out_free = !r_out_vld || !i_out_stall;

    // memory: one read port for the sweep, one write port at commit
    always_ff @(posedge i_clk) begin
        if (do_add) mem[r_pick] <= r_item;
        if (i_cmd.rd_en) r_rd <= mem[i_cmd.rd_idx];
    end

    // interface numbers double as slot-occupied flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < TABLE_SLOTS; s++) begin
                r_iface[s] <= IFACE_NONE;
            end
        end else if (do_add) begin
            r_iface[r_pick] <= r_item_iface;
        end else if (do_del) begin
            r_iface[r_pick] <= IFACE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode        <= i_mode;
            r_item.dest   <= i_dest_addr;
            r_item.mask   <= i_net_mask;
            r_item.gw     <= i_gateway_addr;
            r_item.metric <= i_route_metric;
            r_item_iface  <= i_iface_num;
        end
        if (i_cmd.rd_en) begin
            r_cmp_idx  <= i_cmd.rd_idx;
            r_rd_iface <= r_iface[i_cmd.rd_idx];
        end
        if (take) begin
            r_pick        <= r_cmp_idx;
            r_best_mask   <= r_rd.mask;
            r_best_metric <= r_rd.metric;
            r_best_gw     <= r_rd.gw;
            r_best_iface  <= r_rd_iface;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status    <= STATUS_FAIL;
            r_out_iface <= IFACE_NONE;
            r_fwd_addr  <= '0;
            case (r_mode)
                MODE_ADD: begin
                    if (r_found && add_ok) r_status <= STATUS_OK;
                end
                MODE_DEL: begin
                    if (r_found) r_status <= STATUS_OK;
                end
                MODE_LOOKUP: begin
                    if (r_found) begin
                        r_status    <= STATUS_OK;
                        r_out_iface <= r_best_iface;
                        r_fwd_addr  <= (r_best_gw != '0) ? r_best_gw : r_item.dest;
                    end
                end
                default: begin
                    r_status <= STATUS_FAIL;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_status    = r_status;
    assign o_out_iface = r_out_iface;
    assign o_fwd_addr  = r_fwd_addr;

`ifndef ASSERT_OFF
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !(r_out_vld && i_out_stall))
        else $error("commit while result register is held");
    a_commit_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_vld)
        else $error("result register not loaded after commit");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.commit && (i_cmd.rd_en || r_cmp_vld)))
        else $error("commit overlaps table sweep");
    a_del_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_del |=> (r_iface[r_pick] == IFACE_NONE))
        else $error("deleted slot still occupied");
`endif

endmodule

[hw/rtl/route_table_longest_prefix.sv]
// ----------------------------------------------------------------------------
// route_table_longest_prefix
// ipv4 route table with add, delete and longest-prefix lookup over 16 slots
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------
//  in      | sink      | i_in_valid / o_in_stall   | mode, dest, mask, gw, iface, metric
//  out     | source    | o_out_valid / i_out_stall | status, out_iface, fwd_addr
//
//  every item runs through these steps in order: taking the transfer, a sweep of
//  all slots through the single read port of the route memory, a drain of the
//  compare stage and a commit of the table update and the result
//  reset is synchronous and active low; it marks every slot free at once
//  a finished result waits in the output register while the next item is taken
//  a stalled output only holds the commit step, and with it the input side
//
module route_table_longest_prefix import rtlpm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [ADDR_W-1:0]   i_dest_addr,
    input  logic [ADDR_W-1:0]   i_net_mask,
    input  logic [ADDR_W-1:0]   i_gateway_addr,
    input  logic [IFACE_W-1:0]  i_iface_num,
    input  logic [METRIC_W-1:0] i_route_metric,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_status,
    output logic [IFACE_W-1:0]  o_out_iface,
    output logic [ADDR_W-1:0]   o_fwd_addr
);

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: idle, sweep of all slots, drain, commit
    rtlpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: storage, compare, best-match tracking, result register
    rtlpm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_mode         (i_mode),
        .i_dest_addr    (i_dest_addr),
        .i_net_mask     (i_net_mask),
        .i_gateway_addr (i_gateway_addr),
        .i_iface_num    (i_iface_num),
        .i_route_metric (i_route_metric),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_out_iface    (o_out_iface),
        .o_fwd_addr     (o_fwd_addr)
    );

endmodule

[dv/route_table_longest_prefix_tb.sv]
// ----------------------------------------------------------------------------
// route_table_longest_prefix_tb
// self-checking bench for the 16-slot longest-prefix route table: a local
// copy of the table predicts every add, delete and lookup at input transfer,
// and each output transfer is compared in order against those predictions,
// under random gaps on the sender and random stalls on the receiver
// ----------------------------------------------------------------------------
module route_table_longest_prefix_tb import rtlpm_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // mode code that the block leaves unused
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // cycles with no transfer on either channel before the run is abandoned
    localparam int IDLE_LIMIT  = 2000;
    // settling time after the last result, longer than one item takes to pass the block
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_OPS  = 1200;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [ADDR_W-1:0]   dest;
        logic [ADDR_W-1:0]   mask;
        logic [ADDR_W-1:0]   gw;
        logic [IFACE_W-1:0]  iface;
        logic [METRIC_W-1:0] metric;
    } t_route_op;

    typedef struct packed {
        logic               status;
        logic [IFACE_W-1:0] iface;
        logic [ADDR_W-1:0]  hop;
    } t_route_reply;

    // clock, reset and block ports; the driven ones are known from time zero
    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic                o_in_stall;
    logic [MODE_W-1:0]   i_mode         = '0;
    logic [ADDR_W-1:0]   i_dest_addr    = '0;
    logic [ADDR_W-1:0]   i_net_mask     = '0;
    logic [ADDR_W-1:0]   i_gateway_addr = '0;
    logic [IFACE_W-1:0]  i_iface_num    = '0;
    logic [METRIC_W-1:0] i_route_metric = '0;
    logic                o_out_valid;
    logic                i_out_stall    = 1'b0;
    logic                o_status;
    logic [IFACE_W-1:0]  o_out_iface;
    logic [ADDR_W-1:0]   o_fwd_addr;

    // local copy of the route table
    logic [ADDR_W-1:0]   tbl_dest   [TABLE_SLOTS];
    logic [ADDR_W-1:0]   tbl_mask   [TABLE_SLOTS];
    logic [ADDR_W-1:0]   tbl_gw     [TABLE_SLOTS];
    logic [IFACE_W-1:0]  tbl_iface  [TABLE_SLOTS];
    logic [METRIC_W-1:0] tbl_metric [TABLE_SLOTS];

    t_route_reply expected_replies[$];
    t_route_reply want;
    int           err_count   = 0;
    int           idle_cycles = 0;
    int           stall_left  = 0;
    int           stall_gap   = 0;
    bit           gaps_on     = 1'b1;
    bit           stalls_on   = 1'b1;

    route_table_longest_prefix dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_dest_addr    (i_dest_addr),
        .i_net_mask     (i_net_mask),
        .i_gateway_addr (i_gateway_addr),
        .i_iface_num    (i_iface_num),
        .i_route_metric (i_route_metric),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_out_iface    (o_out_iface),
        .o_fwd_addr     (o_fwd_addr)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // applies one operation to the local table and returns the reply it causes
    function automatic t_route_reply apply_route_op(input t_route_op op);
        t_route_reply rep;
        bit           have;
        int           pick;
        rep  = '{status: STATUS_FAIL, iface: IFACE_NONE, hop: '0};
        have = 1'b0;
        pick = 0;
        case (op.mode)
            MODE_ADD: begin
                // lowest free slot is written, even when the new interface
                // leaves it free
                if (op.iface <= IFACE_LIMIT) begin
                    for (int s = 0; s < TABLE_SLOTS; s++) begin
                        if (tbl_iface[s] == IFACE_NONE) begin
                            tbl_dest[s]   = op.dest;
                            tbl_mask[s]   = op.mask;
                            tbl_gw[s]     = op.gw;
                            tbl_iface[s]  = op.iface;
                            tbl_metric[s] = op.metric;
                            rep.status    = STATUS_OK;
                            break;
                        end
                    end
                end
            end
            MODE_DEL: begin
                for (int s = 0; s < TABLE_SLOTS; s++) begin
                    if (tbl_iface[s] != IFACE_NONE && tbl_dest[s] == op.dest &&
                        tbl_mask[s] == op.mask) begin
                        tbl_dest[s]   = '0;
                        tbl_mask[s]   = '0;
                        tbl_gw[s]     = '0;
                        tbl_iface[s]  = IFACE_NONE;
                        tbl_metric[s] = '0;
                        rep.status    = STATUS_OK;
                        break;
                    end
                end
            end
            MODE_LOOKUP: begin
                // largest mask wins, then strictly lower metric, then lower slot
                for (int s = 0; s < TABLE_SLOTS; s++) begin
                    if (tbl_iface[s] != IFACE_NONE &&
                        (op.dest & tbl_mask[s]) == (tbl_dest[s] & tbl_mask[s])) begin
                        if (!have || tbl_mask[s] > tbl_mask[pick] ||
                            (tbl_mask[s] == tbl_mask[pick] &&
                             tbl_metric[s] < tbl_metric[pick])) begin
                            have = 1'b1;
                            pick = s;
                        end
                    end
                end
                if (have) begin
                    rep.status = STATUS_OK;
                    rep.iface  = tbl_iface[pick];
                    rep.hop    = (tbl_gw[pick] != '0) ? tbl_gw[pick] : op.dest;
                end
            end
            default: begin
                // unused mode leaves the table alone and fails
            end
        endcase
        return rep;
    endfunction

    function automatic bit table_has_free();
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            if (tbl_iface[s] == IFACE_NONE) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [ADDR_W-1:0] prefix_mask(input int len);
        return (len == 0) ? '0 : (32'hFFFF_FFFF << (ADDR_W - len));
    endfunction

    function automatic t_route_op make_op(input logic [MODE_W-1:0] mode,
                                          input logic [ADDR_W-1:0] dest,
                                          input logic [ADDR_W-1:0] mask,
                                          input logic [ADDR_W-1:0] gw,
                                          input logic [IFACE_W-1:0] iface,
                                          input logic [METRIC_W-1:0] metric);
        return '{mode: mode, dest: dest, mask: mask, gw: gw, iface: iface,
                 metric: metric};
    endfunction

    // mostly back to back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------------
    // input channel
    // ------------------------------------------------------------------------

    // drives valid low, keeping the input channel idle
    task automatic idle_in(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // drives one operation, waits for its transfer and records the reply; when no
    // gap is drawn, valid is left high so that a following operation can go back to back
    task automatic send_op(input t_route_op op);
        int gap;
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_mode         <= op.mode;
        i_dest_addr    <= op.dest;
        i_net_mask     <= op.mask;
        i_gateway_addr <= op.gw;
        i_iface_num    <= op.iface;
        i_route_metric <= op.metric;
        do @(posedge i_clk); while (o_in_stall);
        expected_replies.push_back(apply_route_op(op));
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) idle_in(gap);
    endtask

    // sender holds off until every reply has come back
    task automatic drain_replies();
        idle_in(1);
        while (expected_replies.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // output channel: random stall stretches, disabled during quiet phases
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n || !stalls_on) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            stall_left--;
        end else if (i_out_stall) begin
            i_out_stall <= 1'b0;
            stall_left = $urandom_range(0, 6);
        end else begin
            stall_gap = pick_gap();
            if (stall_gap != 0) begin
                i_out_stall <= 1'b1;
                stall_left = stall_gap - 1;
            end
        end
    end

    // every output transfer is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_replies.size() == 0) begin
                $error("result transfer with nothing expected");
                err_count++;
            end else begin
                want = expected_replies.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    err_count++;
                end
                if (o_out_iface !== want.iface) begin
                    $error("out_iface: expected %0d, actual %0d", want.iface,
                           o_out_iface);
                    err_count++;
                end
                if (o_fwd_addr !== want.hop) begin
                    $error("fwd_addr: expected %h, actual %h", want.hop, o_fwd_addr);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else if (i_rst_n) begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $error("no transfer for %0d cycles", IDLE_LIMIT);
                $display("route_table_longest_prefix_tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // lookup and delete on an empty table, and the unused mode
    task automatic test_empty_table();
        send_op(make_op(MODE_LOOKUP, 32'hC0A8_0101, '0, '0, IFACE_NONE, '0));
        send_op(make_op(MODE_DEL, '0, '0, '0, IFACE_NONE, '0));
        send_op(make_op(MODE_UNUSED, '1, '1, '1, '1, '1));
    endtask

    // default route and host route, field extremes
    task automatic test_prefix_extremes();
        send_op(make_op(MODE_ADD, '0, '0, '1, IFACE_LIMIT, '1));
        send_op(make_op(MODE_ADD, '1, '1, '0, 4'd1, '0));
        // host route hit with a zero gateway returns the packet destination
        send_op(make_op(MODE_LOOKUP, '1, '0, '0, IFACE_NONE, '0));
        send_op(make_op(MODE_LOOKUP, '0, '0, '0, IFACE_NONE, '0));
        send_op(make_op(MODE_LOOKUP, 32'h8000_0000, '0, '0, IFACE_NONE, '0));
    endtask

    // equal masks broken by metric, deletes and a free-interface add
    task automatic test_metric_ties();
        send_op(make_op(MODE_ADD, 32'h0A00_0000, prefix_mask(8), 32'h0A00_00FE,
                        4'd2, 16'd5));
        send_op(make_op(MODE_ADD, 32'h0A00_0000, prefix_mask(8), '0, 4'd3, 16'd5));
        send_op(make_op(MODE_ADD, 32'h0A00_0000, prefix_mask(8), 32'h0A00_00FD,
                        4'd4, 16'd4));
        send_op(make_op(MODE_LOOKUP, 32'h0A01_0203, '0, '0, IFACE_NONE, '0));
        send_op(make_op(MODE_DEL, 32'h0A00_0000, prefix_mask(8), '0, IFACE_NONE, '0));
        send_op(make_op(MODE_LOOKUP, 32'h0A01_0203, '0, '0, IFACE_NONE, '0));
        // same destination, other mask: not found
        send_op(make_op(MODE_DEL, 32'h0A00_0000, prefix_mask(16), '0, IFACE_NONE, '0));
        // interface zero writes a slot that stays free, so it never matches
        send_op(make_op(MODE_ADD, 32'h0A0A_0000, prefix_mask(16), 32'h1, IFACE_NONE,
                        16'd0));
        send_op(make_op(MODE_LOOKUP, 32'h0A0A_0001, '0, '0, IFACE_NONE, '0));
    endtask

    // fill every free slot, then one add too many
    task automatic test_table_full();
        while (table_has_free()) begin
            send_op(make_op(MODE_ADD, $urandom, prefix_mask($urandom_range(0, 32)),
                            $urandom, 4'($urandom_range(1, 15)),
                            16'($urandom_range(0, 65535))));
        end
        send_op(make_op(MODE_ADD, 32'h0B00_0000, prefix_mask(8), '0, 4'd7, 16'd1));
        drain_replies();
    endtask

    // mostly well-formed traffic against routes in the table, plus noise
    task automatic test_random_traffic(input int n_ops);
        t_route_op         op;
        int                r;
        int                iter;
        int                done;
        int                occ[$];
        logic [ADDR_W-1:0] base;
        iter = 0;
        done = 0;
        while (done < n_ops) begin
            // phases with and without idling on either side
            if (iter % 150 == 0) begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            if (iter % 400 == 399) drain_replies();
            occ.delete();
            for (int s = 0; s < TABLE_SLOTS; s++) begin
                if (tbl_iface[s] != IFACE_NONE) occ.push_back(s);
            end
            // a few shared networks so masks and metrics collide often
            case ($urandom_range(0, 3))
                0: base = 32'h0A00_0000;
                1: base = 32'hC0A8_0000;
                2: base = 32'hAC10_0000;
                default: base = 32'hFFFF_0000;
            endcase
            r  = $urandom_range(0, 99);
            op = make_op(MODE_LOOKUP, $urandom, $urandom, $urandom,
                         4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
            if (r < 38) begin
                op.mode = MODE_ADD;
                if ($urandom_range(0, 1) != 0) op.dest = base | $urandom_range(0, 255);
                if ($urandom_range(0, 4) != 0) op.mask = prefix_mask($urandom_range(0, 32));
                if ($urandom_range(0, 3) == 0) op.gw = '0;
                if ($urandom_range(0, 9) != 0) op.iface = 4'($urandom_range(1, 15));
                if ($urandom_range(0, 1) != 0) op.metric = 16'($urandom_range(0, 3));
            end else if (r < 63) begin
                op.mode = MODE_DEL;
                if (occ.size() != 0 && $urandom_range(0, 4) != 0) begin
                    r       = occ[$urandom_range(0, occ.size() - 1)];
                    op.dest = tbl_dest[r];
                    op.mask = tbl_mask[r];
                    // near miss: right destination, wrong mask
                    if ($urandom_range(0, 9) == 0) op.mask = op.mask ^ (1 << $urandom_range(0, 31));
                end
            end else if (r < 95) begin
                if (occ.size() != 0 && $urandom_range(0, 9) < 7) begin
                    r       = occ[$urandom_range(0, occ.size() - 1)];
                    op.dest = (tbl_dest[r] & tbl_mask[r]) | ($urandom & ~tbl_mask[r]);
                end
            end else begin
                op.mode = MODE_UNUSED;
            end
            send_op(op);
            if (op.mode != MODE_UNUSED) done++;
            iter++;
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            tbl_dest[s]   = '0;
            tbl_mask[s]   = '0;
            tbl_gw[s]     = '0;
            tbl_iface[s]  = IFACE_NONE;
            tbl_metric[s] = '0;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_prefix_extremes();
        test_metric_ties();
        test_table_full();
        test_random_traffic(RANDOM_OPS);

        // let the last results arrive, then a short quiet tail
        drain_replies();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_replies.size() != 0) begin
            $error("%0d results never arrived", expected_replies.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("route_table_longest_prefix_tb: PASS");
        end else begin
            $display("route_table_longest_prefix_tb: FAIL");
        end
        $finish;
    end

endmodule
